/* hw/rtl/dft_pkg.sv */
// Shared types and constants of the DShot frame transmitter.
package dft_pkg;

   localparam int unsigned THR_W    = 11;
   localparam int unsigned FRAME_W  = 16;
   localparam int unsigned PAYLD_W  = 12;
   localparam int unsigned CRC_W    = 4;
   localparam int unsigned CFG_W    = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned BITCNT_W = 4;

   localparam logic [THR_W-1:0] THROTTLE_MAX = 11'd1999;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_TICKS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ONE_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ZERO_TICKS = 2'd2;

   localparam logic [CFG_W-1:0] CELL_TICKS_RST     = 8'd24;
   localparam logic [CFG_W-1:0] LOW_ONE_TICKS_RST  = 8'd6;
   localparam logic [CFG_W-1:0] LOW_ZERO_TICKS_RST = 8'd18;
   localparam logic [CFG_W-1:0] CELL_TICKS_MIN     = 8'd2;
   localparam logic [CFG_W-1:0] LOW_TICKS_MIN      = 8'd1;

   // Remainder left by a single set payload bit at each position (poly 0x05)
   localparam logic [CRC_W-1:0] CRC_COL [PAYLD_W] = '{
      4'h1, 4'h2, 4'h4, 4'h8, 4'h5, 4'hA,
      4'h1, 4'h2, 4'h4, 4'h8, 4'h5, 4'hA
   };

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_FRAME = 3'b010,
      PH_GAP   = 3'b100
   } phase_type;

   typedef struct packed {
      logic               is_send;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   typedef struct packed {
      logic [CFG_W-1:0] cell_ticks;
      logic [CFG_W-1:0] low_one_ticks;
      logic [CFG_W-1:0] low_zero_ticks;
   } cfg_type;

endpackage

/* hw/rtl/dft_front.sv */
// Front end: classifies a request and encodes a send into a finished frame.
module dft_front (
   input  logic                      req_is_send,
   input  logic [dft_pkg::THR_W-1:0] req_throttle,
   output dft_pkg::entry_type        entry
);
   import dft_pkg::*;

   logic [THR_W-1:0]   thr_sat;
   logic [PAYLD_W-1:0] payload;
   logic [CRC_W-1:0]   rem;

   always_comb begin
      thr_sat = (req_throttle > THROTTLE_MAX) ? THROTTLE_MAX : req_throttle;
      // telemetry bit is always clear
      payload = {thr_sat, 1'b0};
      rem = '0;
      for (int p = 0; p < PAYLD_W; p++) begin
         if (payload[p]) begin
            rem = rem ^ CRC_COL[p];
         end
      end
      entry.is_send = req_is_send;
      entry.frame   = {payload, ~rem};
   end

endmodule

/* hw/rtl/dft_queue.sv */
// Two-entry queue between the front end and the waveform engine.
module dft_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dft_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output dft_pkg::entry_type pop_entry
);
   import dft_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/dft_back.sv */
// Waveform engine: runs frame and gap timing, one queued request per cycle while step is high.
module dft_back (
   input  logic               clock,
   input  logic               reset,
   input  dft_pkg::cfg_type   cfg,
   input  logic               step,
   input  dft_pkg::entry_type entry,
   output logic               pin_level,
   output logic               busy_res,
   output logic               rejected
);
   import dft_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [FRAME_W-1:0]  shift_ff, shift_in;
   logic [BITCNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [CFG_W-1:0]    tick_ff, tick_in;
   logic                line_ff, line_in;

   logic [CFG_W-1:0] cell_eff;
   logic [CFG_W-1:0] low_raw;
   logic [CFG_W-1:0] low_eff;
   logic [CFG_W:0]   tick_sum;
   logic             cell_done;
   logic             busy_now;

   always_comb begin
      cell_eff  = (cfg.cell_ticks < CELL_TICKS_MIN) ? CELL_TICKS_MIN : cfg.cell_ticks;
      low_raw   = shift_ff[FRAME_W-1] ? cfg.low_one_ticks : cfg.low_zero_ticks;
      low_eff   = (low_raw < LOW_TICKS_MIN) ? LOW_TICKS_MIN : low_raw;
      if (low_eff > cell_eff - 8'd1) begin
         low_eff = cell_eff - 8'd1;
      end
      // nine bits: a wrap past 255 also ends the cell
      tick_sum  = {1'b0, tick_ff} + 9'd1;
      cell_done = (tick_sum >= {1'b0, cell_eff});
      busy_now  = (phase_ff != PH_IDLE);
   end

   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      bitcnt_in = bitcnt_ff;
      tick_in   = tick_ff;
      line_in   = line_ff;
      rejected  = 1'b0;
      if (entry.is_send) begin
         if (busy_now) begin
            rejected = 1'b1;
         end else begin
            phase_in  = PH_FRAME;
            shift_in  = entry.frame;
            bitcnt_in = '0;
            tick_in   = '0;
            line_in   = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_FRAME: begin
               line_in = (tick_ff < low_eff) ? 1'b0 : 1'b1;
               if (cell_done) begin
                  tick_in = '0;
                  if (bitcnt_ff == {BITCNT_W{1'b1}}) begin
                     phase_in = PH_GAP;
                  end else begin
                     bitcnt_in = bitcnt_ff + 1'b1;
                     shift_in  = {shift_ff[FRAME_W-2:0], 1'b0};
                  end
               end else begin
                  tick_in = tick_sum[CFG_W-1:0];
               end
            end
            PH_GAP: begin
               line_in = 1'b1;
               if (cell_done) begin
                  tick_in  = '0;
                  phase_in = PH_IDLE;
               end else begin
                  tick_in = tick_sum[CFG_W-1:0];
               end
            end
            default: begin
               phase_in = PH_IDLE;
               line_in  = 1'b1;
            end
         endcase
      end
      pin_level = line_in;
      busy_res  = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         shift_ff  <= '0;
         bitcnt_ff <= '0;
         tick_ff   <= '0;
         line_ff   <= 1'b1;
      end else if (step) begin
         phase_ff  <= phase_in;
         shift_ff  <= shift_in;
         bitcnt_ff <= bitcnt_in;
         tick_ff   <= tick_in;
         line_ff   <= line_in;
      end
   end

endmodule

/* hw/rtl/dshot_frame_transmitter.sv */
// Top level of the DShot frame transmitter: front end, queue, waveform engine.
//
//  Channel   Direction  Carries
//  req_*     in         tuser: cmd (1 = send, 0 = tick); tdata: throttle
//  rsp_*     out        tdata: pin_level, busy_res, rejected
//  csr_*     in         register writes: cell_ticks, low_one_ticks, low_zero_ticks
//
//  One request enters and one response leaves per cycle when neither side stalls.
//  A request is queued at acceptance and stepped through the engine once the
//  output register is free; its response is registered there at that step.
//  While a response waits on rsp_tready the two-entry queue fills, then req_tready
//  drops until the response is taken.
//  Synchronous active-high reset: line idles high, queue empty, no response held.
module dshot_frame_transmitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [10:0] throttle, [15:11] zero
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] pin_level, [1] busy_res, [2] rejected, [7:3] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import dft_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type front_entry;
   entry_type q_entry;
   logic      q_full;
   logic      q_valid;
   logic      push;
   logic      step;

   logic       pin_level;
   logic       busy_res;
   logic       rejected;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_data_ff, rsp_data_in;

   // Register file: writes land directly, no read-back
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CELL_TICKS:     cfg_in.cell_ticks     = csr_wdata;
            CSR_LOW_ONE_TICKS:  cfg_in.low_one_ticks  = csr_wdata;
            CSR_LOW_ZERO_TICKS: cfg_in.low_zero_ticks = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_ticks     <= CELL_TICKS_RST;
         cfg_ff.low_one_ticks  <= LOW_ONE_TICKS_RST;
         cfg_ff.low_zero_ticks <= LOW_ZERO_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: encode the request before it is queued
   dft_front u_front (
      .req_is_send  (req_tuser),
      .req_throttle (req_tdata[THR_W-1:0]),
      .entry        (front_entry)
   );

   assign req_tready = ~q_full;
   assign push       = req_tvalid & req_tready;

   dft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (step),
      .not_empty  (q_valid),
      .pop_entry  (q_entry)
   );

   // Advance the engine whenever a queued request exists and the output slot frees
   assign step = q_valid & (~rsp_valid_ff | rsp_tready);

   dft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .entry     (q_entry),
      .pin_level (pin_level),
      .busy_res  (busy_res),
      .rejected  (rejected)
   );

   // Output register: hold until taken, reload on each step
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rejected, busy_res, pin_level};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

   // A rejected send only happens while a frame or its gap is pending
   a_reject_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid & rsp_tdata[2] |-> rsp_tdata[1])
      else $error("rejection reported while idle");

   // The line only goes low inside a frame
   a_low_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid & ~rsp_tdata[0] |-> rsp_tdata[1])
      else $error("line low while idle");

   // A full queue always has an entry to drain
   a_full_valid : assert property (@(posedge clock) disable iff (reset)
      ~req_tready |-> q_valid)
      else $error("queue full yet empty");

   // The engine never steps while a held response is stalled
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff & ~rsp_tready |-> ~step)
      else $error("response overwritten while stalled");

endmodule

/* dv/dshot_frame_transmitter_test.sv */
// Self-checking stream testbench for the DShot frame transmitter.
`timescale 1ns / 1ps

module dshot_frame_transmitter_test;
   import dft_pkg::*;

   // Cycles with no handshake on either channel before the run is abandoned.
   localparam int STALL_LIMIT     = 2000;
   // Length of the long receiver hold-off that backs the queue up.
   localparam int HOLD_OFF_CYCLES = 60;
   // Drain margin after the last response; waited out before any register write.
   localparam int DRAIN_CYCLES    = 4;
   // The fourth index on the register port has no register behind it.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic rejected;
   } line_sample_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [10:0] throttle, [15:11] zero
   logic        req_tuser  = 1'b0; // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] pin_level, [1] busy_res, [2] rejected
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [7:0]  csr_wdata  = '0;

   // Shadow of the transmitter: register copies and waveform state.
   cfg_type            shadow_cfg;
   logic [FRAME_W-1:0] frame_bits;
   logic [4:0]         bits_sent;
   logic [7:0]         cell_pos;
   phase_type          tx_phase;
   logic               line_high;
   line_sample_type    expected_lines[$];

   // Traffic knobs: steady_flow switches random idling off on both sides;
   // each bump of hold_asks starts one long hold-off in the receiver.
   bit steady_flow = 1'b0;
   int hold_asks   = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int mismatches  = 0;
   int stall_count = 0;

   dshot_frame_transmitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // 4-bit checksum: shift the payload MSB first through a 5-bit remainder,
   // fold with 0x05 whenever the top bit is set, and invert the low nibble.
   function automatic logic [CRC_W-1:0] frame_crc(logic [PAYLD_W-1:0] payload);
      logic [4:0] rem;
      rem = '0;
      for (int k = PAYLD_W - 1; k >= 0; k--) begin
         rem = {rem[3:0], payload[k]};
         if (rem[4]) rem = rem ^ 5'h05;
      end
      return ~rem[3:0];
   endfunction

   // Clamp a low width into 1 .. cell-1.
   function automatic logic [7:0] low_width(logic [7:0] raw, logic [7:0] cell_len);
      logic [7:0] w;
      w = (raw < LOW_TICKS_MIN) ? LOW_TICKS_MIN : raw;
      if (w > cell_len - 8'd1) w = cell_len - 8'd1;
      return w;
   endfunction

   task automatic reset_line_model();
      shadow_cfg.cell_ticks     = CELL_TICKS_RST;
      shadow_cfg.low_one_ticks  = LOW_ONE_TICKS_RST;
      shadow_cfg.low_zero_ticks = LOW_ZERO_TICKS_RST;
      frame_bits = '0;
      bits_sent  = '0;
      cell_pos   = '0;
      tx_phase   = PH_IDLE;
      line_high  = 1'b1;
   endtask

   // Advance the shadow by one request and return the response it causes.
   function automatic line_sample_type advance_line_model(logic is_send,
                                                          logic [THR_W-1:0] thr);
      line_sample_type    r;
      logic [THR_W-1:0]   thr_sat;
      logic [PAYLD_W-1:0] payload;
      logic [7:0]         cell_len;
      logic [7:0]         low;
      logic               busy;
      busy = (tx_phase != PH_IDLE);
      r.rejected = 1'b0;
      cell_len = (shadow_cfg.cell_ticks < CELL_TICKS_MIN) ? CELL_TICKS_MIN
                                                          : shadow_cfg.cell_ticks;
      if (is_send) begin
         if (busy) begin
            // A send into a busy line is dropped; nothing moves.
            r.rejected = 1'b1;
         end else begin
            thr_sat    = (thr > THROTTLE_MAX) ? THROTTLE_MAX : thr;
            payload    = {thr_sat, 1'b0};  // telemetry bit always clear
            frame_bits = {payload, frame_crc(payload)};
            bits_sent  = '0;
            cell_pos   = '0;
            tx_phase   = PH_FRAME;
            line_high  = 1'b1;
         end
      end else if (tx_phase == PH_FRAME) begin
         low = low_width(frame_bits[4'd15 - bits_sent[3:0]] ? shadow_cfg.low_one_ticks
                                                            : shadow_cfg.low_zero_ticks,
                         cell_len);
         line_high = (cell_pos < low) ? 1'b0 : 1'b1;
         cell_pos  = cell_pos + 8'd1;
         if (cell_pos >= cell_len || cell_pos == 8'd0) begin
            cell_pos  = '0;
            bits_sent = bits_sent + 5'd1;
            if (bits_sent >= 5'd16) begin
               bits_sent = 5'd16;
               tx_phase  = PH_GAP;
            end
         end
      end else if (tx_phase == PH_GAP) begin
         line_high = 1'b1;
         cell_pos  = cell_pos + 8'd1;
         if (cell_pos >= cell_len || cell_pos == 8'd0) begin
            cell_pos  = '0;
            bits_sent = '0;
            tx_phase  = PH_IDLE;
         end
      end else begin
         tx_phase  = PH_IDLE;
         line_high = 1'b1;
      end
      r.pin_level = line_high;
      r.busy_res  = (tx_phase != PH_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one request from the falling edge, maybe after a short gap, and
   // hold it until the rising edge that takes it.
   task automatic send_request(logic is_send, logic [THR_W-1:0] thr);
      @(negedge clock);
      if (!steady_flow && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_send;
      req_tdata  <= {{(16 - THR_W){1'b0}}, thr};
      do begin
         @(posedge clock);
      end while (!req_tready);
      expected_lines.push_back(advance_line_model(is_send, thr));
   endtask

   task automatic run_ticks(int count);
      repeat (count) send_request(1'b0, THR_W'($urandom_range(2047)));
   endtask

   // Tick on until the frame and its idle cell are over.
   task automatic finish_frame();
      while (tx_phase != PH_IDLE) send_request(1'b0, THR_W'($urandom_range(2047)));
   endtask

   // Drop valid, wait for every outstanding response, then let the pipe empty.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CELL_TICKS:     shadow_cfg.cell_ticks     = val;
         CSR_LOW_ONE_TICKS:  shadow_cfg.low_one_ticks  = val;
         CSR_LOW_ZERO_TICKS: shadow_cfg.low_zero_ticks = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_timing(logic [7:0] cell_len, logic [7:0] one_w, logic [7:0] zero_w);
      set_register(CSR_CELL_TICKS, cell_len);
      set_register(CSR_LOW_ONE_TICKS, one_w);
      set_register(CSR_LOW_ZERO_TICKS, zero_w);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Ticks on an idle line keep it high and report not busy.
   task automatic test_idle_ticks();
      run_ticks(4);
   endtask

   // Throttle extremes, saturation and the checksum; a second send straight
   // after the first must be rejected without disturbing the frame.
   task automatic test_throttle_extremes();
      logic [THR_W-1:0] picks[6] = '{11'd0, 11'd1, 11'd1999, 11'd2000,
                                     11'd2047, 11'h555};
      settle();
      set_timing(8'd3, 8'd1, 8'd2);
      foreach (picks[i]) begin
         send_request(1'b1, picks[i]);
         send_request(1'b1, THR_W'($urandom_range(2047)));
         run_ticks(2);
         send_request(1'b1, ~picks[i]);
         finish_frame();
      end
      run_ticks(1);
   endtask

   // Register values outside the legal range, and a write to the empty index.
   task automatic test_clamped_timing();
      settle();
      set_timing(8'd0, 8'd0, 8'd200);      // cell acts as 2, both widths 1
      send_request(1'b1, THR_W'($urandom_range(2047)));
      finish_frame();
      settle();
      set_timing(8'd1, 8'd7, 8'd0);
      send_request(1'b1, THR_W'($urandom_range(2047)));
      finish_frame();
      settle();
      set_timing(8'd5, 8'd254, 8'd0);      // one clamps to 4, zero rises to 1
      set_register(CSR_UNUSED, CFG_W'($urandom_range(255)));
      send_request(1'b1, THR_W'($urandom_range(2047)));
      finish_frame();
   endtask

   // Change timing while a frame is still on the line; the next tick uses it.
   task automatic test_midframe_update();
      settle();
      set_timing(8'd6, 8'd2, 8'd4);
      send_request(1'b1, THR_W'($urandom_range(2047)));
      run_ticks(20);
      settle();
      set_timing(8'd3, 8'd1, 8'd2);
      run_ticks(5);
      settle();
      set_register(CSR_LOW_ZERO_TICKS, 8'd9);   // clamps to 2 in a 3-tick cell
      finish_frame();
   endtask

   // Hold the receiver off while requests keep coming, so the queue fills and
   // req_tready drops; then pause the sender until every response is back.
   task automatic test_backpressure();
      settle();
      set_timing(8'd4, 8'd1, 8'd3);
      send_request(1'b1, THR_W'($urandom_range(2047)));
      hold_asks++;
      run_ticks(40);
      settle();
      run_ticks(10);
      finish_frame();
   endtask

   // Mostly ticks with occasional sends; many sends land on a busy line.
   task automatic test_random_traffic();
      logic [7:0]       cell_len;
      logic [THR_W-1:0] thr;
      logic             is_send;
      for (int round = 0; round < 6; round++) begin
         settle();
         steady_flow = (round == 2);
         if (round == 4) begin
            // out-of-range settings
            set_timing(CFG_W'($urandom_range(6)), CFG_W'($urandom_range(255)),
                       CFG_W'($urandom_range(255)));
         end else begin
            cell_len = CFG_W'($urandom_range(8, 2));
            set_timing(cell_len, CFG_W'($urandom_range(cell_len - 1, 1)),
                       CFG_W'($urandom_range(cell_len - 1, 1)));
         end
         repeat (20) begin
            is_send = ($urandom_range(9) == 0);
            thr = ($urandom_range(3) == 0) ? THR_W'($urandom_range(2047, 1990))
                                           : THR_W'($urandom_range(2047));
            send_request(is_send, thr);
         end
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------

   // Drive rsp_tready on the falling edge; a fresh hold request starts a
   // long hold-off counted here.
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(99) >= 7);
      end
   end

   // Compare each response taken with the oldest prediction.
   always @(posedge clock) begin
      line_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lines.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_lines.pop_front();
            if (rsp_tdata[0] !== want.pin_level) begin
               $error("pin_level: expected %0d, got %0d", want.pin_level, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[1] !== want.busy_res) begin
               $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_tdata[1]);
               mismatches++;
            end
            if (rsp_tdata[2] !== want.rejected) begin
               $error("rejected: expected %0d, got %0d", want.rejected, rsp_tdata[2]);
               mismatches++;
            end
         end
      end
   end

   // Abandon the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset_line_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_throttle_extremes();
      test_clamped_timing();
      test_midframe_update();
      test_backpressure();
      test_random_traffic();

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
